@@ design/rbsi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray / box slab intersection unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int AXES       = 3;
  localparam int DATA_W     = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 13;
  localparam int NUM_W      = DIV_STAGES * DIV_BITS;
  localparam int QUO_W      = 49;
  localparam int T_W        = 51;
  localparam int ADDR_W     = 5;

  // Register indexes
  localparam logic [2:0] REG_LOW_X  = 3'd0;
  localparam logic [2:0] REG_LOW_Y  = 3'd1;
  localparam logic [2:0] REG_LOW_Z  = 3'd2;
  localparam logic [2:0] REG_HIGH_X = 3'd3;
  localparam logic [2:0] REG_HIGH_Y = 3'd4;
  localparam logic [2:0] REG_HIGH_Z = 3'd5;

  localparam logic [DATA_W-1:0] LOW_RESET  = 32'h0000_0000;
  localparam logic [DATA_W-1:0] HIGH_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] MISS_T     = 32'hFFFF_0000;

  // Stand-in for an unbounded slab end, above any real quotient
  localparam logic signed [T_W-1:0] T_UNB = 51'sh2_0000_0000_0000;
  localparam logic signed [T_W-1:0] T_MAX = 51'sh0_0000_7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 51'sh7_FFFF_8000_0000;

  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] lo;
    logic [AXES-1:0][DATA_W-1:0] hi;
  } box_t;

  typedef struct packed {
    logic [AXES-1:0] neg0;
    logic [AXES-1:0] neg1;
    logic [AXES-1:0] zero;
    logic [AXES-1:0] miss;
  } side_t;

endpackage
`default_nettype wire

@@ design/ray_box_slab_intersect_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray against axis-aligned box slab test in signed Q16.16.
// ----------------------------------------------------------------------------
// One ray enters per cycle while the pipeline is not held, and one word
// (hit, entry_t) leaves per ray, in order. A ray passes one input register,
// six 13-stage dividers (four quotient bits per stage, the 49-bit slab
// parameters) and three stages that order, reduce and saturate. The whole
// pipeline holds while a result word is stalled; ray_stall follows res_stall
// whenever a result is waiting. The box corners must be written over APB
// only while no ray is in flight; the block itself does not enforce this.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              ray_valid,
  output logic                   ray_stall,
  input  wire logic [DATA_W-1:0] origin_x,
  input  wire logic [DATA_W-1:0] origin_y,
  input  wire logic [DATA_W-1:0] origin_z,
  input  wire logic [DATA_W-1:0] dir_x,
  input  wire logic [DATA_W-1:0] dir_y,
  input  wire logic [DATA_W-1:0] dir_z,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic                   hit,
  output logic      [DATA_W-1:0] entry_t
);

  box_t                        box;
  logic                        en;
  logic [AXES-1:0][DATA_W-1:0] org, dir;

  logic                        s0_valid;
  side_t                       s0_side;
  logic [AXES-1:0][NUM_W-1:0]  s0_num0, s0_num1;
  logic [AXES-1:0][DATA_W-1:0] s0_den;
  side_t                       side_w;
  logic [AXES-1:0][NUM_W-1:0]  num0_w, num1_w;
  logic [AXES-1:0][DATA_W-1:0] den_w;

  logic [DIV_STAGES-1:0]       dv_valid;
  side_t                       dv_side [DIV_STAGES];
  logic [AXES-1:0][QUO_W-1:0]  q0, q1;

  rbsi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .box
  );

  // Hold everything while a finished word is stalled
  assign en        = !(res_valid && res_stall);
  assign ray_stall = res_valid && res_stall;

  assign org = {origin_z, origin_y, origin_x};
  assign dir = {dir_z, dir_y, dir_x};

  // Form numerator and divisor magnitudes, signs and zero-direction cases
  always_comb begin
    logic signed [DATA_W:0]   n0, n1;
    logic        [DATA_W:0]   m0, m1;
    logic signed [DATA_W-1:0] lo, hi, o, d, bmin, bmax;
    for (int a = 0; a < AXES; a++) begin
      lo = $signed(box.lo[a]);
      hi = $signed(box.hi[a]);
      o  = $signed(org[a]);
      d  = $signed(dir[a]);
      n0 = {lo[DATA_W-1], lo} - {o[DATA_W-1], o};
      n1 = {hi[DATA_W-1], hi} - {o[DATA_W-1], o};
      m0 = n0[DATA_W] ? -n0 : n0;
      m1 = n1[DATA_W] ? -n1 : n1;
      num0_w[a] = {3'b000, m0, 16'h0000};
      num1_w[a] = {3'b000, m1, 16'h0000};
      den_w[a]  = d[DATA_W-1] ? -d : d;
      side_w.neg0[a] = n0[DATA_W] ^ d[DATA_W-1];
      side_w.neg1[a] = n1[DATA_W] ^ d[DATA_W-1];
      side_w.zero[a] = (d == '0);
      bmin = (lo < hi) ? lo : hi;
      bmax = (lo < hi) ? hi : lo;
      side_w.miss[a] = side_w.zero[a] && ((o < bmin) || (o > bmax));
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= side_w;
      s0_num0 <= num0_w;
      s0_num1 <= num1_w;
      s0_den  <= den_w;
    end
  end

  // Dividers, two per axis
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbsi_div_pipe u_div0 (
      .clk, .en, .num(s0_num0[a]), .den(s0_den[a]), .quo(q0[a])
    );
    rbsi_div_pipe u_div1 (
      .clk, .en, .num(s0_num1[a]), .den(s0_den[a]), .quo(q1[a])
    );
  end

  // Carry valid and side flags alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (en) begin
      dv_valid <= {dv_valid[DIV_STAGES-2:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s0_side;
      for (int s = 1; s < DIV_STAGES; s++) dv_side[s] <= dv_side[s-1];
    end
  end

  rbsi_slab_reduce u_reduce (
    .clk, .rst, .en,
    .in_valid (dv_valid[DIV_STAGES-1]),
    .side     (dv_side[DIV_STAGES-1]),
    .q0, .q1,
    .out_valid(res_valid),
    .hit, .entry_t
  );

endmodule
`default_nettype wire

@@ design/rbsi_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_cfg
// APB register file holding the two box corners.
// ----------------------------------------------------------------------------
module rbsi_cfg import rbsi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output box_t                   box
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // Write one corner coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        box.lo[a] <= LOW_RESET;
        box.hi[a] <= HIGH_RESET;
      end
    end else if (wr) begin
      case (idx)
        REG_LOW_X:  box.lo[0] <= pwdata;
        REG_LOW_Y:  box.lo[1] <= pwdata;
        REG_LOW_Z:  box.lo[2] <= pwdata;
        REG_HIGH_X: box.hi[0] <= pwdata;
        REG_HIGH_Y: box.hi[1] <= pwdata;
        REG_HIGH_Z: box.hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_LOW_X:  prdata = box.lo[0];
      REG_LOW_Y:  prdata = box.lo[1];
      REG_LOW_Z:  prdata = box.lo[2];
      REG_HIGH_X: prdata = box.hi[0];
      REG_HIGH_Y: prdata = box.hi[1];
      REG_HIGH_Z: prdata = box.hi[2];
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/rbsi_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// Pipelined unsigned restoring divider, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module rbsi_div_pipe import rbsi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DATA_W-1:0] den,
  output logic      [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0]  nreg [DIV_STAGES];
  logic [DATA_W-1:0] rreg [DIV_STAGES];
  logic [DATA_W-1:0] dreg [DIV_STAGES];
  logic [NUM_W-1:0]  qreg [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0]  n_in, n_w, q_in, q_w;
    logic [DATA_W-1:0] r_in, r_w, d_in;
    logic [DATA_W:0]   t;

    if (s == 0) begin : g_first
      assign n_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = nreg[s-1];
      assign r_in = rreg[s-1];
      assign d_in = dreg[s-1];
      assign q_in = qreg[s-1];
    end

    // Shift in one numerator bit and try a subtract, DIV_BITS times
    always_comb begin
      n_w = n_in;
      r_w = r_in;
      q_w = q_in;
      t   = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
        t   = {r_w, n_w[NUM_W-1]};
        n_w = {n_w[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t   = t - {1'b0, d_in};
          q_w = {q_w[NUM_W-2:0], 1'b1};
        end else begin
          q_w = {q_w[NUM_W-2:0], 1'b0};
        end
        r_w = t[DATA_W-1:0];
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (en) begin
        nreg[s] <= n_w;
        rreg[s] <= r_w;
        dreg[s] <= d_in;
        qreg[s] <= q_w;
      end
    end
  end

  assign quo = qreg[DIV_STAGES-1][QUO_W-1:0];

endmodule
`default_nettype wire

@@ design/rbsi_slab_reduce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_slab_reduce
// Signs the quotients, orders slab pairs, reduces over the axes and
// saturates the entry parameter. Three register stages.
// ----------------------------------------------------------------------------
module rbsi_slab_reduce import rbsi_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire side_t                      side,
  input  wire logic [AXES-1:0][QUO_W-1:0] q0,
  input  wire logic [AXES-1:0][QUO_W-1:0] q1,
  output logic                            out_valid,
  output logic                            hit,
  output logic      [DATA_W-1:0]          entry_t
);

  logic                            a_valid, a_miss;
  logic signed [AXES-1:0][T_W-1:0] a_enter, a_leave;
  logic                            b_valid, b_miss;
  logic signed [T_W-1:0]           b_max_e, b_min_l;

  logic signed [AXES-1:0][T_W-1:0] enter_w, leave_w;
  logic signed [T_W-1:0]           max_w, min_w, t0, t1;

  // Sign the quotients and order each pair
  always_comb begin
    t0 = '0;
    t1 = '0;
    for (int a = 0; a < AXES; a++) begin
      t0 = $signed({2'b00, q0[a]});
      t1 = $signed({2'b00, q1[a]});
      if (side.neg0[a]) t0 = -t0;
      if (side.neg1[a]) t1 = -t1;
      if (side.zero[a]) begin
        enter_w[a] = -T_UNB;
        leave_w[a] = T_UNB;
      end else if (t0 < t1) begin
        enter_w[a] = t0;
        leave_w[a] = t1;
      end else begin
        enter_w[a] = t1;
        leave_w[a] = t0;
      end
    end
  end

  // Largest entry, smallest exit; compare each element as signed
  always_comb begin
    max_w = a_enter[0];
    min_w = a_leave[0];
    for (int a = 1; a < AXES; a++) begin
      if ($signed(a_enter[a]) > max_w) max_w = a_enter[a];
      if ($signed(a_leave[a]) < min_w) min_w = a_leave[a];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_miss  <= |side.miss;
      a_enter <= enter_w;
      a_leave <= leave_w;
      b_miss  <= a_miss;
      b_max_e <= max_w;
      b_min_l <= min_w;
      if (b_miss || (b_min_l < b_max_e)) begin
        hit     <= 1'b0;
        entry_t <= MISS_T;
      end else begin
        hit <= 1'b1;
        if (b_max_e > T_MAX)      entry_t <= T_MAX[DATA_W-1:0];
        else if (b_max_e < T_MIN) entry_t <= T_MIN[DATA_W-1:0];
        else                      entry_t <= b_max_e[DATA_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire
